[rtl/rlzd_pkg.sv]
// Shared types, codes and helper functions of the RefPack stream decoder.
package rlzd_pkg;

  // Header bytes and command boundaries.
  localparam logic [7:0] HDR_BYTE0   = 8'h10;
  localparam logic [7:0] HDR_BYTE1   = 8'hFB;
  localparam logic [7:0] CMD_TWO     = 8'h80;
  localparam logic [7:0] CMD_THREE   = 8'hC0;
  localparam logic [7:0] CMD_FOUR    = 8'hE0;
  localparam logic [7:0] CMD_STOP    = 8'hFC;

  // Chunk geometry.
  localparam int unsigned CHUNK_BYTES = 32;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned LEN_W       = 24;
  localparam int unsigned COPY_W      = 11;
  localparam int unsigned OFF_W       = 18;

  // Status codes.
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_PASS   = 2'd1;
  localparam logic [1:0] STAT_OFFSET = 2'd2;
  localparam logic [1:0] STAT_LENGTH = 2'd3;

  // Error flag bits.
  localparam logic [1:0] ERR_OFFSET = 2'b01;
  localparam logic [1:0] ERR_LENGTH = 2'b10;

  // Parser phase.
  typedef enum logic [3:0] {
    PH_H0   = 4'd0,
    PH_H1   = 4'd1,
    PH_H2   = 4'd2,
    PH_H3   = 4'd3,
    PH_H4   = 4'd4,
    PH_OP0  = 4'd5,
    PH_OP1  = 4'd6,
    PH_OP2  = 4'd7,
    PH_OP3  = 4'd8,
    PH_LIT  = 4'd9,
    PH_PASS = 4'd10,
    PH_DONE = 4'd11
  } phase_t;

  // Sequencer state.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CSET,
    ST_RD,
    ST_WR,
    ST_FIN
  } state_t;

  // Number of bytes in a command, given its first byte.
  function automatic logic [2:0] cmd_len(input logic [7:0] b0);
    logic [2:0] n;
    if (b0 < CMD_TWO) n = 3'd2;
    else if (b0 < CMD_THREE) n = 3'd3;
    else if (b0 < CMD_FOUR) n = 3'd4;
    else n = 3'd1;
    return n;
  endfunction

  // Literal count that precedes the copy of a command.
  function automatic logic [6:0] cmd_lits(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic room);
    logic [6:0] n;
    if (b0 < CMD_TWO) n = {5'd0, b0[1:0]};
    else if (b0 < CMD_THREE) n = {5'd0, b1[7:6]};
    else if (b0 < CMD_FOUR) n = {5'd0, b0[1:0]};
    else if (b0 < CMD_STOP) n = {b0[4:0], 2'b00} + 7'd4;
    else n = room ? {5'd0, b0[1:0]} : 7'd0;
    return n;
  endfunction

  // Status code from flags; offset errors win over length errors.
  function automatic logic [1:0] flag_status(input logic [1:0] flags);
    logic [1:0] s;
    if (flags[0]) s = STAT_OFFSET;
    else if (flags[1]) s = STAT_LENGTH;
    else s = STAT_OK;
    return s;
  endfunction

endpackage

[rtl/refpack_lz_stream_decoder.sv]
// RefPack stream decoder: header parse, command decode, history copies, chunk packing.
// A byte that yields a chunk without a copy goes to the finish state, which loads the chunk;
// output back-pressure holds the step until the output register is free. No new input byte
// is taken until a step is done; a back-reference adds a setup state, then a read state and
// a write state per copied byte, set by the read-then-write of the single history RAM.
// Reset clears all control state at once; the history RAM is not cleared.
module refpack_lz_stream_decoder #(
  parameter int unsigned WINDOW_BYTES = 131072
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] in_byte
  input  logic         s_tuser,   // [0] first_byte
  input  logic         s_tlast,   // end_of_file
  output logic         m_tvalid,
  input  logic         m_tready,
  // [63:0] bytes_0_7, [127:64] bytes_8_15, [191:128] bytes_16_23,
  // [255:192] bytes_24_31, [261:256] byte_count, [285:262] declared_length, zero pad
  output logic [287:0] m_tdata,
  output logic [2:0]   m_tuser,   // [0] stream_done, [2:1] status
  output logic         m_tlast    // run_last
);

  localparam int unsigned AW = $clog2(WINDOW_BYTES);
  localparam int unsigned LW = rlzd_pkg::LEN_W;

  // Registers.
  rlzd_pkg::state_t            state, state_next;
  rlzd_pkg::phase_t            phase, phase_next;
  logic [LW-1:0]               wp, wp_next;
  logic [LW-1:0]               len_exp, len_exp_next;
  logic [7:0]                  cmd [4];
  logic [7:0]                  cmd_next [4];
  logic [6:0]                  lits, lits_next;
  logic [1:0]                  flags, flags_next;
  logic [1:0]                  flags_before, flags_before_next;
  logic                        step_out, step_out_next;
  logic [255:0]                acc, acc_next;
  logic [rlzd_pkg::CNT_W-1:0]  acc_cnt, acc_cnt_next;
  logic [rlzd_pkg::COPY_W-1:0] copy_cnt, copy_cnt_next;
  logic [rlzd_pkg::OFF_W-1:0]  copy_off, copy_off_next;
  logic [1:0]                  pred_status, pred_status_next;
  logic                        pred_done, pred_done_next;

  // Output register.
  logic [255:0]                o_bytes;
  logic [rlzd_pkg::CNT_W-1:0]  o_cnt;
  logic [LW-1:0]               o_len;
  logic [1:0]                  o_status;
  logic                        o_done;
  logic                        o_last;

  // Load strobe for the output register.
  logic                        ld;
  logic                        ld_last;
  logic [1:0]                  ld_status;
  logic                        ld_done;
  logic                        out_free;

  // RAM ports.
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [7:0]                  ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [7:0]                  ram_rdata;
  logic                        lit_we;
  logic                        copy_we;
  logic [1:0]                  copy_flags;

  // Step decode scratch.
  logic                        first;
  logic [7:0]                  b;
  rlzd_pkg::phase_t            ph_b;
  logic [LW-1:0]               wp_b;
  logic [LW-1:0]               len_b;
  logic [6:0]                  lits_b;
  logic [1:0]                  flags_b;
  logic [7:0]                  ob0;
  logic [7:0]                  ob1;
  logic [1:0]                  ocnt;
  logic                        cmd_full;
  logic                        fin_cmd;
  logic                        go_copy;
  logic [6:0]                  new_lits;
  logic [rlzd_pkg::COPY_W-1:0] c_len;
  logic [rlzd_pkg::OFF_W-1:0]  c_off;
  logic [1:0]                  c_pflags;
  logic [LW:0]                 c_end;
  logic [4:0]                  app_idx;
  logic [LW-1:0]               rd_src;
  logic [1:0]                  fin_status;
  logic                        fin_need;

  rlzd_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW_BYTES)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == rlzd_pkg::ST_IDLE);
  assign first    = s_tuser;
  assign b        = s_tdata;
  assign rd_src   = wp - LW'(copy_off);

  // History writes: literals on their transfer, copied bytes from the read data.
  assign ram_we    = (state == rlzd_pkg::ST_IDLE && s_tvalid && lit_we) || copy_we;
  assign ram_waddr = copy_we ? wp[AW-1:0] : wp_b[AW-1:0];
  assign ram_wdata = copy_we ? ram_rdata : b;

  // Copy parameters from the stored command.
  always_comb begin
    if (cmd[0] < rlzd_pkg::CMD_TWO) begin
      c_len = rlzd_pkg::COPY_W'({1'b0, cmd[0][4:2]}) + 11'd3;
      c_off = rlzd_pkg::OFF_W'({cmd[0][6:5], cmd[1]}) + 18'd1;
    end else if (cmd[0] < rlzd_pkg::CMD_THREE) begin
      c_len = rlzd_pkg::COPY_W'(cmd[0][5:0]) + 11'd4;
      c_off = rlzd_pkg::OFF_W'({cmd[1][5:0], cmd[2]}) + 18'd1;
    end else begin
      c_len = {1'b0, cmd[0][3:2], cmd[3]} + 11'd5;
      c_off = {1'b0, cmd[0][4], cmd[1], cmd[2]} + 18'd1;
    end
    c_end = {1'b0, wp} + (LW+1)'(c_len);
    if (LW'(c_off) > wp) begin
      c_pflags = flags | rlzd_pkg::ERR_OFFSET;
    end else if (c_end > {1'b0, len_exp}) begin
      c_pflags = flags | rlzd_pkg::ERR_LENGTH;
    end else begin
      c_pflags = flags;
    end
  end

  // Status at the end of a step.
  always_comb begin
    if (phase == rlzd_pkg::PH_PASS ||
        (phase == rlzd_pkg::PH_DONE && len_exp == '0 && step_out &&
         flags == 2'b00 && wp == '0)) begin
      fin_status = rlzd_pkg::STAT_PASS;
    end else begin
      fin_status = rlzd_pkg::flag_status(flags);
    end
    fin_need = (acc_cnt != '0) || (phase == rlzd_pkg::PH_DONE) || (flags != flags_before);
  end

  // Decode of one accepted byte against the state after an optional restart.
  always_comb begin
    ph_b    = first ? rlzd_pkg::PH_H0 : phase;
    wp_b    = first ? '0 : wp;
    len_b   = first ? '0 : len_exp;
    lits_b  = first ? '0 : lits;
    flags_b = first ? 2'b00 : flags;
    for (int i = 0; i < 4; i++) begin
      cmd_next[i] = first ? 8'd0 : cmd[i];
    end
    phase_next   = ph_b;
    len_exp_next = len_b;
    lits_next    = lits_b;
    wp_next      = wp_b;
    flags_next   = flags_b;
    ob0      = 8'd0;
    ob1      = 8'd0;
    ocnt     = 2'd0;
    cmd_full = 1'b0;
    fin_cmd  = 1'b0;
    go_copy  = 1'b0;
    new_lits = 7'd0;
    lit_we   = 1'b0;
    case (ph_b)
      rlzd_pkg::PH_H0: begin
        if (b == rlzd_pkg::HDR_BYTE0) begin
          phase_next = rlzd_pkg::PH_H1;
        end else begin
          phase_next = rlzd_pkg::PH_PASS;
          ob0  = b;
          ocnt = 2'd1;
        end
      end
      rlzd_pkg::PH_H1: begin
        if (b == rlzd_pkg::HDR_BYTE1) begin
          phase_next = rlzd_pkg::PH_H2;
        end else begin
          phase_next = rlzd_pkg::PH_PASS;
          ob0  = rlzd_pkg::HDR_BYTE0;
          ob1  = b;
          ocnt = 2'd2;
        end
      end
      rlzd_pkg::PH_H2: begin
        len_exp_next = {len_b[15:0], b};
        phase_next   = rlzd_pkg::PH_H3;
      end
      rlzd_pkg::PH_H3: begin
        len_exp_next = {len_b[15:0], b};
        phase_next   = rlzd_pkg::PH_H4;
      end
      rlzd_pkg::PH_H4: begin
        len_exp_next = {len_b[15:0], b};
        phase_next   = rlzd_pkg::PH_OP0;
      end
      rlzd_pkg::PH_OP0: begin
        cmd_next[0] = b;
        cmd_next[1] = 8'd0;
        cmd_next[2] = 8'd0;
        cmd_next[3] = 8'd0;
        if (rlzd_pkg::cmd_len(b) == 3'd1) cmd_full = 1'b1;
        else phase_next = rlzd_pkg::PH_OP1;
      end
      rlzd_pkg::PH_OP1: begin
        cmd_next[1] = b;
        if (rlzd_pkg::cmd_len(cmd_next[0]) <= 3'd2) cmd_full = 1'b1;
        else phase_next = rlzd_pkg::PH_OP2;
      end
      rlzd_pkg::PH_OP2: begin
        cmd_next[2] = b;
        if (rlzd_pkg::cmd_len(cmd_next[0]) <= 3'd3) cmd_full = 1'b1;
        else phase_next = rlzd_pkg::PH_OP3;
      end
      rlzd_pkg::PH_OP3: begin
        cmd_next[3] = b;
        cmd_full    = 1'b1;
      end
      rlzd_pkg::PH_LIT: begin
        if (wp_b >= len_b) begin
          flags_next = flags_b | rlzd_pkg::ERR_LENGTH;
        end else begin
          lit_we  = 1'b1;
          ob0     = b;
          ocnt    = 2'd1;
          wp_next = wp_b + 24'd1;
        end
        lits_next = lits_b - 7'd1;
        if (lits_next == 7'd0) fin_cmd = 1'b1;
      end
      rlzd_pkg::PH_PASS: begin
        ob0  = b;
        ocnt = 2'd1;
      end
      default: begin
      end
    endcase
    // A complete command: literals first, else straight to its copy.
    if (cmd_full) begin
      new_lits = rlzd_pkg::cmd_lits(cmd_next[0], cmd_next[1], wp_b < len_b);
      if (new_lits != 7'd0) begin
        lits_next  = new_lits;
        phase_next = rlzd_pkg::PH_LIT;
      end else begin
        lits_next = 7'd0;
        fin_cmd   = 1'b1;
      end
    end
    if (fin_cmd) begin
      go_copy    = (cmd_next[0] < rlzd_pkg::CMD_FOUR);
      phase_next = (cmd_next[0] >= rlzd_pkg::CMD_STOP) ? rlzd_pkg::PH_DONE : rlzd_pkg::PH_OP0;
    end
    if (s_tlast) begin
      phase_next = rlzd_pkg::PH_DONE;
    end
  end

  // Sequencer: next state, RAM reads, chunk packing and output loads.
  always_comb begin
    state_next        = state;
    flags_before_next = flags_before;
    step_out_next     = step_out;
    acc_next          = acc;
    acc_cnt_next      = acc_cnt;
    copy_cnt_next     = copy_cnt;
    copy_off_next     = copy_off;
    pred_status_next  = pred_status;
    pred_done_next    = pred_done;
    ram_re    = 1'b0;
    ram_raddr = rd_src[AW-1:0];
    ld        = 1'b0;
    ld_last   = 1'b0;
    ld_status = fin_status;
    ld_done   = 1'b0;
    app_idx   = acc_cnt[4:0];
    case (state)
      rlzd_pkg::ST_IDLE: begin
        if (s_tvalid && ph_b != rlzd_pkg::PH_DONE) begin
          flags_before_next = flags_b;
          step_out_next     = (ocnt != 2'd0);
          acc_next          = {240'd0, ob1, ob0};
          acc_cnt_next      = rlzd_pkg::CNT_W'(ocnt);
          state_next        = go_copy ? rlzd_pkg::ST_CSET : rlzd_pkg::ST_FIN;
        end
      end
      rlzd_pkg::ST_CSET: begin
        copy_cnt_next    = c_len;
        copy_off_next    = c_off;
        pred_status_next = rlzd_pkg::flag_status(c_pflags);
        pred_done_next   = (phase == rlzd_pkg::PH_DONE);
        if (LW'(c_off) > wp || wp >= len_exp) state_next = rlzd_pkg::ST_FIN;
        else state_next = rlzd_pkg::ST_RD;
      end
      rlzd_pkg::ST_RD: begin
        ram_re     = 1'b1;
        state_next = rlzd_pkg::ST_WR;
      end
      rlzd_pkg::ST_WR: begin
        if (acc_cnt != rlzd_pkg::CNT_W'(rlzd_pkg::CHUNK_BYTES) || out_free) begin
          if (acc_cnt == rlzd_pkg::CNT_W'(rlzd_pkg::CHUNK_BYTES)) begin
            ld        = 1'b1;
            ld_status = pred_status;
            ld_done   = pred_done;
            acc_next  = '0;
            app_idx   = 5'd0;
          end
          acc_next[8*app_idx +: 8] = ram_rdata;
          acc_cnt_next  = rlzd_pkg::CNT_W'(app_idx) + 6'd1;
          step_out_next = 1'b1;
          copy_cnt_next = copy_cnt - 11'd1;
          if (copy_cnt == 11'd1 || wp + 24'd1 >= len_exp) state_next = rlzd_pkg::ST_FIN;
          else state_next = rlzd_pkg::ST_RD;
        end
      end
      rlzd_pkg::ST_FIN: begin
        if (!fin_need) begin
          state_next = rlzd_pkg::ST_IDLE;
        end else if (out_free) begin
          ld         = 1'b1;
          ld_last    = 1'b1;
          ld_done    = (phase == rlzd_pkg::PH_DONE);
          acc_next   = '0;
          acc_cnt_next = '0;
          state_next = rlzd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rlzd_pkg::ST_IDLE;
      end
    endcase
  end

  // A copied byte is written back while its chunk has room.
  assign copy_we = (state == rlzd_pkg::ST_WR) &&
                   (acc_cnt != rlzd_pkg::CNT_W'(rlzd_pkg::CHUNK_BYTES) || out_free);

  always_comb begin
    copy_flags = flags;
    if (state == rlzd_pkg::ST_CSET) begin
      if (LW'(c_off) > wp) copy_flags = flags | rlzd_pkg::ERR_OFFSET;
      else if (wp >= len_exp) copy_flags = flags | rlzd_pkg::ERR_LENGTH;
    end else if (copy_we && copy_cnt != 11'd1 && wp + 24'd1 >= len_exp) begin
      copy_flags = flags | rlzd_pkg::ERR_LENGTH;
    end
  end

  // State register and decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rlzd_pkg::ST_IDLE;
      phase        <= rlzd_pkg::PH_H0;
      wp           <= '0;
      len_exp      <= '0;
      lits         <= '0;
      flags        <= 2'b00;
      flags_before <= 2'b00;
      step_out     <= 1'b0;
      acc_cnt      <= '0;
      for (int i = 0; i < 4; i++) begin
        cmd[i] <= 8'd0;
      end
    end else begin
      state        <= state_next;
      flags_before <= flags_before_next;
      step_out     <= step_out_next;
      acc_cnt      <= acc_cnt_next;
      if (state == rlzd_pkg::ST_IDLE && s_tvalid && ph_b != rlzd_pkg::PH_DONE) begin
        phase   <= phase_next;
        wp      <= wp_next;
        len_exp <= len_exp_next;
        lits    <= lits_next;
        flags   <= flags_next;
        for (int i = 0; i < 4; i++) begin
          cmd[i] <= cmd_next[i];
        end
      end else begin
        flags <= copy_flags;
        if (copy_we) begin
          wp <= wp + 24'd1;
        end
      end
    end
  end

  // Payload registers of the chunk builder.
  always_ff @(posedge clk) begin
    acc         <= acc_next;
    copy_cnt    <= copy_cnt_next;
    copy_off    <= copy_off_next;
    pred_status <= pred_status_next;
    pred_done   <= pred_done_next;
  end

  // Output register: loads when empty or when the current chunk is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ld) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      o_bytes  <= acc;
      o_cnt    <= acc_cnt;
      o_len    <= len_exp;
      o_status <= ld_status;
      o_done   <= ld_done;
      o_last   <= ld_last;
    end
  end

  assign m_tdata = {2'b00, o_len, o_cnt, o_bytes};
  assign m_tuser = {o_status, o_done};
  assign m_tlast = o_last;

endmodule

[rtl/rlzd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module rlzd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/rlzd_checker.sv]
// Port-level checker for the RefPack stream decoder, bound to the top level.
module rlzd_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [7:0]   s_tdata,
  input logic         s_tuser,
  input logic         s_tlast,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [287:0] m_tdata,
  input logic [2:0]   m_tuser,
  input logic         m_tlast
);

  // A chunk never holds more than 32 bytes.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[261:256] <= 6'd32)
    else $error("chunk byte count above 32");

  // Only the last chunk of a step may be partly filled.
  a_full_unless_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> m_tdata[261:256] == 6'd32)
    else $error("non-final chunk not full");

  // A stalled chunk keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled chunk changed");

  // Reset leaves the output empty and the input ready.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("decoder not idle after reset");

endmodule

bind refpack_lz_stream_decoder rlzd_checker u_rlzd_checker (.*);
